/* hw/rtl/audio_slaved_media_clock_assert.svh */
`ifndef AUDIO_SLAVED_MEDIA_CLOCK_ASSERT_SVH
`define AUDIO_SLAVED_MEDIA_CLOCK_ASSERT_SVH

// same-cycle implication, checked outside reset
`define ASMC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define ASMC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/asmc_pkg.sv */
package asmc_pkg;

  localparam logic [18:0] RATE_DEFAULT = 19'd48000;
  localparam logic [29:0] NS_PER_S     = 30'd1000000000;
  localparam logic [63:0] POS_MAX      = 64'h7fff_ffff_ffff_ffff;
  localparam int unsigned DIV_BITS     = 94;
  localparam int unsigned CNT_W        = $clog2(DIV_BITS);

  typedef enum logic [2:0] {
    CMD_QUERY  = 3'd0,
    CMD_PLAY   = 3'd1,
    CMD_PAUSE  = 3'd2,
    CMD_SEEK   = 3'd3,
    CMD_RERATE = 3'd4,
    CMD_SOURCE = 3'd5
  } cmd_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISP,
    S_CP,
    S_MUL_LO,
    S_MUL_HI,
    S_SUM,
    S_DIV,
    S_ADD,
    S_POST,
    S_REANCHOR,
    S_OUT
  } state_e;

endpackage

/* hw/rtl/audio_slaved_media_clock.sv */
// Media position clock slaved to an audio played-frame counter.
// Input stream: s_axis_tuser carries the command and the frames_ok flag,
// s_axis_tdata the counter reading and the seek target. Each transaction
// yields exactly one output transaction with the clock position, the
// running flag and the reading-rejected flag.
// The user must write sample_rate through cfg_we_i / cfg_wdata_i only while
// idle; the block itself does not enforce it. Zero means 48000 frames per second.
// Commands that take no reading while running, or whose running reading
// is rejected, take a short path to m_axis_tvalid. A believed running
// reading for a query, pause, rerate or source change goes through the
// two-pass 32x30 multiply of the frame delta and the 94-step bit-serial
// divide by the sample rate that follows it, and a rerate or source
// change also re-anchors in S_REANCHOR.
// One item at a time: s_axis_tready is high only while the block is idle,
// so a new transaction is accepted only after the result has been taken.
// The result stays in registers with m_axis_tvalid high until
// m_axis_tready takes it; a stalled receiver holds the block and the
// input stays not ready.
// Reset: clock paused at position 0, no anchor, no reading seen, sample
// rate 48000, both channels empty.
module audio_slaved_media_clock
  import asmc_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [18:0]  cfg_wdata_i,    // sample_rate
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [127:0] s_axis_tdata,   // frames[62:0], target_ns[126:63], zero[127]
  input  logic [3:0]   s_axis_tuser,   // cmd[2:0], frames_ok[3]
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [71:0]  m_axis_tdata    // position_ns[63:0], is_playing[64],
                                       // reading_rejected[65], zero[71:66]
);

  state_e state_q, state_d;

  logic [18:0]        rate_q;
  logic [2:0]         cmd_q, cmd_d;
  logic [62:0]        f_q, f_d;
  logic               ok_q, ok_d;
  logic signed [63:0] tgt_q, tgt_d;
  logic               rej_q, rej_d;
  logic               running_q, running_d;
  logic signed [63:0] paused_q, paused_d;
  logic signed [63:0] ap_q, ap_d;
  logic signed [63:0] lp_q, lp_d;
  logic signed [63:0] here_q, here_d;
  logic [62:0]        af_q, af_d;
  logic               av_q, av_d;
  logic [62:0]        hr_q, hr_d;
  logic               hv_q, hv_d;
  logic [63:0]        delta_q, delta_d;
  logic [61:0]        prod_lo_q, prod_lo_d;
  logic [61:0]        prod_hi_q, prod_hi_d;
  logic [DIV_BITS-1:0] dvd_q, dvd_d;
  logic [18:0]        rem_q, rem_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;

  logic [18:0]        rate_eff;
  logic               take_ok;
  logic [31:0]        mul_a;
  logic [61:0]        mul_p;
  logic [19:0]        trial;
  logic               trial_ge;
  logic [63:0]        elapsed;
  logic [64:0]        sum65;
  logic signed [63:0] sum_sat;
  logic signed [63:0] pos_out;

  assign rate_eff = (rate_q == '0) ? RATE_DEFAULT : rate_q;
  assign take_ok  = ok_q && !(hv_q && (f_q < hr_q));

  assign mul_a = (state_q == S_MUL_HI) ? delta_q[63:32] : delta_q[31:0];
  assign mul_p = {30'd0, mul_a} * {32'd0, NS_PER_S};

  assign trial    = {rem_q, dvd_q[DIV_BITS-1]};
  assign trial_ge = trial >= {1'b0, rate_eff};

  assign elapsed = (dvd_q[DIV_BITS-1:63] != '0) ? POS_MAX : {1'b0, dvd_q[62:0]};
  assign sum65   = {ap_q[63], ap_q} + {1'b0, elapsed};
  assign sum_sat = (sum65[64:63] == 2'b01) ? POS_MAX : sum65[63:0];

  assign pos_out       = running_q ? lp_q : paused_q;
  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = (state_q == S_OUT);
  assign m_axis_tdata  = {6'd0, rej_q, running_q, pos_out};

  always_comb begin
    state_d   = state_q;
    cmd_d     = cmd_q;
    f_d       = f_q;
    ok_d      = ok_q;
    tgt_d     = tgt_q;
    rej_d     = rej_q;
    running_d = running_q;
    paused_d  = paused_q;
    ap_d      = ap_q;
    lp_d      = lp_q;
    here_d    = here_q;
    af_d      = af_q;
    av_d      = av_q;
    hr_d      = hr_q;
    hv_d      = hv_q;
    delta_d   = delta_q;
    prod_lo_d = prod_lo_q;
    prod_hi_d = prod_hi_q;
    dvd_d     = dvd_q;
    rem_d     = rem_q;
    cnt_d     = cnt_q;

    unique case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          cmd_d   = s_axis_tuser[2:0];
          ok_d    = s_axis_tuser[3];
          f_d     = s_axis_tdata[62:0];
          tgt_d   = s_axis_tdata[126:63];
          rej_d   = 1'b0;
          state_d = S_DISP;
        end
      end
      S_DISP: begin
        unique case (cmd_q)
          CMD_PLAY: begin
            if (running_q) begin
              state_d = S_OUT;
            end else begin
              running_d = 1'b1;
              here_d    = paused_q;
              state_d   = S_REANCHOR;
            end
          end
          CMD_PAUSE: state_d = running_q ? S_CP : S_OUT;
          CMD_SEEK: begin
            if (!running_q) begin
              paused_d = tgt_q;
            end
            here_d  = tgt_q;
            state_d = S_REANCHOR;
          end
          CMD_RERATE: state_d = running_q ? S_CP : S_OUT;
          default:    state_d = S_CP;
        endcase
      end
      S_CP: begin
        if (!running_q) begin
          here_d  = paused_q;
          state_d = S_POST;
        end else if (!take_ok) begin
          rej_d   = 1'b1;
          here_d  = lp_q;
          state_d = S_POST;
        end else begin
          hr_d = f_q;
          hv_d = 1'b1;
          if (!av_q) begin
            ap_d    = lp_q;
            af_d    = f_q;
            av_d    = 1'b1;
            delta_d = '0;
          end else begin
            delta_d = {1'b0, f_q} - {1'b0, af_q};
          end
          state_d = S_MUL_LO;
        end
      end
      S_MUL_LO: begin
        prod_lo_d = mul_p;
        state_d   = S_MUL_HI;
      end
      S_MUL_HI: begin
        prod_hi_d = mul_p;
        state_d   = S_SUM;
      end
      S_SUM: begin
        dvd_d   = {prod_hi_q, 32'd0} + {32'd0, prod_lo_q};
        rem_d   = '0;
        cnt_d   = '0;
        state_d = S_DIV;
      end
      S_DIV: begin
        rem_d = trial_ge ? 19'(trial - {1'b0, rate_eff}) : trial[18:0];
        dvd_d = {dvd_q[DIV_BITS-2:0], trial_ge};
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CNT_W'(DIV_BITS - 1)) begin
          state_d = S_ADD;
        end
      end
      S_ADD: begin
        lp_d    = sum_sat;
        here_d  = sum_sat;
        state_d = S_POST;
      end
      S_POST: begin
        unique case (cmd_q)
          CMD_PAUSE: begin
            paused_d  = here_q;
            running_d = 1'b0;
            state_d   = S_OUT;
          end
          CMD_RERATE: state_d = S_REANCHOR;
          CMD_SOURCE: begin
            hv_d    = 1'b0;
            hr_d    = '0;
            state_d = S_REANCHOR;
          end
          default: state_d = S_OUT;
        endcase
      end
      S_REANCHOR: begin
        ap_d = here_q;
        lp_d = here_q;
        if (take_ok) begin
          hr_d = f_q;
          hv_d = 1'b1;
          af_d = f_q;
          av_d = 1'b1;
        end else begin
          rej_d = 1'b1;
          af_d  = '0;
          av_d  = 1'b0;
        end
        state_d = S_OUT;
      end
      S_OUT: begin
        if (m_axis_tready) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      rate_q    <= RATE_DEFAULT;
      rej_q     <= 1'b0;
      running_q <= 1'b0;
      paused_q  <= '0;
      ap_q      <= '0;
      lp_q      <= '0;
      af_q      <= '0;
      av_q      <= 1'b0;
      hr_q      <= '0;
      hv_q      <= 1'b0;
    end else begin
      state_q   <= state_d;
      if (cfg_we_i) begin
        rate_q <= cfg_wdata_i;
      end
      rej_q     <= rej_d;
      running_q <= running_d;
      paused_q  <= paused_d;
      ap_q      <= ap_d;
      lp_q      <= lp_d;
      af_q      <= af_d;
      av_q      <= av_d;
      hr_q      <= hr_d;
      hv_q      <= hv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q     <= cmd_d;
    f_q       <= f_d;
    ok_q      <= ok_d;
    tgt_q     <= tgt_d;
    here_q    <= here_d;
    delta_q   <= delta_d;
    prod_lo_q <= prod_lo_d;
    prod_hi_q <= prod_hi_d;
    dvd_q     <= dvd_d;
    rem_q     <= rem_d;
    cnt_q     <= cnt_d;
  end

`include "audio_slaved_media_clock_assert.svh"

  `ASMC_ASSERT_IMP(a_busy_not_ready, m_axis_tvalid, !s_axis_tready, "ready while result pending")
  `ASMC_ASSERT_NXT(a_accept_dispatch, s_axis_tvalid && s_axis_tready, state_q == S_DISP, "accept without dispatch")
  `ASMC_ASSERT_IMP(a_rem_below_rate, state_q == S_DIV, rem_q < rate_eff, "divider remainder out of range")
  `ASMC_ASSERT_IMP(a_highest_cleared, !hv_q, hr_q == '0, "stale highest reading")
  `ASMC_ASSERT_IMP(a_anchor_order, av_q && hv_q, af_q <= hr_q, "anchor frame above highest reading")

endmodule
